/* rtl/core/dq_pkg.sv */
package dq_pkg;

  // Ring geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int ENTRY_W  = 5;

  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // Command codes
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_POP_BACK   = 3'd1;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic [ENTRY_W-1:0]       entry_count;
    logic [1:0]               status;
  } dq_out_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;   // run the accepted command
    logic load;   // capture the read word into the result
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_go; // the offered command is a pop that will succeed
  } dq_stat_t;

  // (base + off) mod CAPACITY; base < CAPACITY and off <= CAPACITY
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Count shown in the 5-bit result field
  function automatic logic [ENTRY_W-1:0] count_field(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[ENTRY_W-1:0];
  endfunction

endpackage

/* rtl/core/double_ended_queue_top.sv */
// Bounded deque of 32-bit words held in a 16-entry ring RAM.
// Push, clear and refused commands show their beat in the cycle after
// acceptance; a successful pop first waits in a load state for the registered
// RAM read. One command at a time: no new command is taken until the result
// handshake completes.
// Reset clears front index and count; RAM is not cleared.
module double_ended_queue_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dq_pkg::dq_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dq_pkg::dq_out_t out_data_o
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dq_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .stat_o    (stat),
    .out_data_o(out_data_o)
  );

endmodule

/* rtl/core/dq_ram.sv */
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/dq_ctrl.sv */
module dq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  dq_pkg::dq_stat_t stat_i,
  output dq_pkg::dq_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept      = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.exec  = accept;
  assign cmd_o.load  = (state_q == S_LOAD);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = stat_i.pop_go ? S_LOAD : S_OUT;
        end
      end
      S_LOAD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/dq_datapath.sv */
module dq_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dq_pkg::dq_cmd_t  cmd_i,
  input  dq_pkg::dq_in_t   in_data_i,
  output dq_pkg::dq_stat_t stat_o,
  output dq_pkg::dq_out_t  out_data_o
);

  logic [dq_pkg::IDX_W-1:0]  front_q, front_d;
  logic [dq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [1:0]                status_d;
  logic                      full, empty;
  logic                      we, re;
  logic [dq_pkg::IDX_W-1:0]  waddr, raddr;
  logic [dq_pkg::WORD_W-1:0] rdata;
  dq_pkg::dq_out_t           res_q;

  assign full  = (count_q == dq_pkg::CAP_CNT);
  assign empty = (count_q == '0);

  // Command decode and pointer update
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = dq_pkg::ST_DONE;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = dq_pkg::ring_pos(front_q, count_q);
    raddr    = front_q;
    unique case (in_data_i.command)
      dq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status_d = dq_pkg::ST_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      dq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status_d = dq_pkg::ST_FULL;
        end else begin
          front_d = (front_q == '0) ? dq_pkg::LAST_IDX : front_q - 1'b1;
          waddr   = front_d;
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      dq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status_d = dq_pkg::ST_EMPTY;
        end else begin
          raddr   = dq_pkg::ring_pos(front_q, count_q - 1'b1);
          re      = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status_d = dq_pkg::ST_EMPTY;
        end else begin
          re      = 1'b1;
          front_d = dq_pkg::ring_pos(front_q, dq_pkg::CNT_W'(1));
          count_d = count_q - 1'b1;
        end
      end
      dq_pkg::CMD_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.pop_go = re;

  dq_ram #(
    .WIDTH(dq_pkg::WORD_W),
    .DEPTH(dq_pkg::CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && we),
    .waddr_i(waddr),
    .wdata_i(in_data_i.push_value),
    .re_i   (cmd_i.exec && re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Result register; the popped word lands in the cycle after the read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q.popped_value <= '0;
      res_q.entry_count  <= dq_pkg::count_field(count_d);
      res_q.status       <= status_d;
    end else if (cmd_i.load) begin
      res_q.popped_value <= rdata;
    end
  end

  assign out_data_o = res_q;

endmodule

/* rtl/core/dq_checker.sv */
module dq_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input dq_pkg::dq_out_t out_data_o
);

  // A pending result blocks new commands
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("command accepted while a result is pending");

  // After an accepted command the block is busy
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second command accepted back to back");

  // One result beat per command
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result repeated");

  // Refused commands return a zero word and only legal status codes
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != dq_pkg::ST_DONE) |->
      (out_data_o.popped_value == '0 &&
       (out_data_o.status == dq_pkg::ST_EMPTY || out_data_o.status == dq_pkg::ST_FULL)))
    else $error("bad refused result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (.*);
